@@ src/lli_pkg.sv @@
// Shared widths and the divider stage record for the line intersection pipeline.
package lli_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_W    = 32;
    localparam int PROD_W     = 2 * COEF_WIDTH;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int HIGH_W     = NUM_W - COEF_WIDTH;
    localparam int IN_W       = 6 * FIELD_W;
    localparam int OUT_W      = 2 * FIELD_W;

    typedef struct packed {
        logic                    valid;
        logic                    hit;
        logic                    neg_x;
        logic                    neg_y;
        logic                    ovf_x;
        logic                    ovf_y;
        logic [PROD_W-1:0]       den;
        logic [PROD_W-1:0]       rem_x;
        logic [PROD_W-1:0]       rem_y;
        logic [COEF_WIDTH-1:0]   low_x;
        logic [COEF_WIDTH-1:0]   low_y;
        logic [COEF_WIDTH-1:0]   q_x;
        logic [COEF_WIDTH-1:0]   q_y;
    } t_div;

endpackage

@@ src/lli_front.sv @@
// Products, differences, sign-magnitude split and divider setup (four stages).
module lli_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [lli_pkg::IN_W-1:0]    i_data,
    output lli_pkg::t_div               o_stage
);

    localparam int CW = lli_pkg::COEF_WIDTH;
    localparam int PW = lli_pkg::PROD_W;
    localparam int FW = lli_pkg::FIELD_W;

    logic signed [CW-1:0] a1, b1, c1, a2, b2, c2;

    logic                 r_v1, r_v2, r_v3;
    logic signed [PW-1:0] r_a1b2, r_b1a2, r_b1c2, r_c1b2, r_c1a2, r_a1c2;
    logic signed [PW:0]   r_det, r_nx, r_ny;
    logic                 r_hit, r_neg_x, r_neg_y;
    logic [PW-1:0]        r_den, r_mx, r_my;
    lli_pkg::t_div        r_s4;

    logic [PW-1:0]               mag_det, mag_nx, mag_ny;
    logic [lli_pkg::NUM_W-1:0]   num_x, num_y;
    logic [lli_pkg::HIGH_W-1:0]  high_x, high_y;

    assign a1 = i_data[0*FW +: CW];
    assign b1 = i_data[1*FW +: CW];
    assign c1 = i_data[2*FW +: CW];
    assign a2 = i_data[3*FW +: CW];
    assign b2 = i_data[4*FW +: CW];
    assign c2 = i_data[5*FW +: CW];

    assign mag_det = r_det[PW] ? PW'(-r_det) : PW'(r_det);
    assign mag_nx  = r_nx[PW]  ? PW'(-r_nx)  : PW'(r_nx);
    assign mag_ny  = r_ny[PW]  ? PW'(-r_ny)  : PW'(r_ny);

    assign num_x  = lli_pkg::NUM_W'(r_mx) << lli_pkg::FRAC_BITS;
    assign num_y  = lli_pkg::NUM_W'(r_my) << lli_pkg::FRAC_BITS;
    assign high_x = num_x[lli_pkg::NUM_W-1:CW];
    assign high_y = num_y[lli_pkg::NUM_W-1:CW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_s4.valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1b2 <= a1 * b2;
            r_b1a2 <= b1 * a2;
            r_b1c2 <= b1 * c2;
            r_c1b2 <= c1 * b2;
            r_c1a2 <= c1 * a2;
            r_a1c2 <= a1 * c2;

            r_det <= (PW+1)'(r_a1b2) - (PW+1)'(r_b1a2);
            r_nx  <= (PW+1)'(r_b1c2) - (PW+1)'(r_c1b2);
            r_ny  <= (PW+1)'(r_c1a2) - (PW+1)'(r_a1c2);

            r_hit   <= (r_det != '0);
            r_neg_x <= r_nx[PW] ^ r_det[PW];
            r_neg_y <= r_ny[PW] ^ r_det[PW];
            r_den   <= mag_det;
            r_mx    <= mag_nx;
            r_my    <= mag_ny;

            r_s4.hit   <= r_hit;
            r_s4.neg_x <= r_neg_x;
            r_s4.neg_y <= r_neg_y;
            r_s4.den   <= r_den;
            r_s4.ovf_x <= (PW'(high_x) >= r_den);
            r_s4.ovf_y <= (PW'(high_y) >= r_den);
            r_s4.rem_x <= PW'(high_x);
            r_s4.rem_y <= PW'(high_y);
            r_s4.low_x <= num_x[CW-1:0];
            r_s4.low_y <= num_y[CW-1:0];
            r_s4.q_x   <= '0;
            r_s4.q_y   <= '0;
        end
    end

    assign o_stage = r_s4;

endmodule

@@ src/lli_div_step.sv @@
// One restoring division step for both coordinate quotients.
module lli_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  lli_pkg::t_div i_stage,
    output lli_pkg::t_div o_stage
);

    localparam int CW = lli_pkg::COEF_WIDTH;
    localparam int PW = lli_pkg::PROD_W;

    lli_pkg::t_div n_s, r_s;
    logic [PW-1:0] tx, ty;
    logic          bx, by;

    always_comb begin
        n_s = i_stage;
        tx  = {i_stage.rem_x[PW-2:0], i_stage.low_x[CW-1]};
        ty  = {i_stage.rem_y[PW-2:0], i_stage.low_y[CW-1]};
        bx  = (tx >= i_stage.den);
        by  = (ty >= i_stage.den);
        n_s.rem_x = bx ? tx - i_stage.den : tx;
        n_s.rem_y = by ? ty - i_stage.den : ty;
        n_s.low_x = i_stage.low_x << 1;
        n_s.low_y = i_stage.low_y << 1;
        n_s.q_x   = {i_stage.q_x[CW-2:0], bx};
        n_s.q_y   = {i_stage.q_y[CW-2:0], by};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.valid <= 1'b0;
        end else if (i_en) begin
            r_s.valid <= n_s.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s.hit   <= n_s.hit;
            r_s.neg_x <= n_s.neg_x;
            r_s.neg_y <= n_s.neg_y;
            r_s.ovf_x <= n_s.ovf_x;
            r_s.ovf_y <= n_s.ovf_y;
            r_s.den   <= n_s.den;
            r_s.rem_x <= n_s.rem_x;
            r_s.rem_y <= n_s.rem_y;
            r_s.low_x <= n_s.low_x;
            r_s.low_y <= n_s.low_y;
            r_s.q_x   <= n_s.q_x;
            r_s.q_y   <= n_s.q_y;
        end
    end

    assign o_stage = r_s;

endmodule

@@ src/lli_back.sv @@
// Sign, saturation and the output register.
module lli_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  lli_pkg::t_div            i_stage,
    output logic                     o_valid,
    output logic [lli_pkg::OUT_W-1:0] o_data,
    output logic [1:0]               o_user
);

    localparam int CW = lli_pkg::COEF_WIDTH;
    localparam int FW = lli_pkg::FIELD_W;
    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic          r_valid, r_hit, r_ovf;
    logic [FW-1:0] r_x, r_y;
    logic [CW-1:0] vx, vy;
    logic          sx, sy;

    always_comb begin
        if (i_stage.neg_x) begin
            sx = i_stage.ovf_x || (i_stage.q_x > MINV);
            vx = sx ? MINV : -i_stage.q_x;
        end else begin
            sx = i_stage.ovf_x || (i_stage.q_x > MAXV);
            vx = sx ? MAXV : i_stage.q_x;
        end
        if (i_stage.neg_y) begin
            sy = i_stage.ovf_y || (i_stage.q_y > MINV);
            vy = sy ? MINV : -i_stage.q_y;
        end else begin
            sy = i_stage.ovf_y || (i_stage.q_y > MAXV);
            vy = sy ? MAXV : i_stage.q_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= i_stage.hit;
            r_ovf <= i_stage.hit && (sx || sy);
            r_x   <= i_stage.hit ? FW'(signed'(vx)) : '0;
            r_y   <= i_stage.hit ? FW'(signed'(vy)) : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_y, r_x};
    assign o_user  = {r_ovf, r_hit};

endmodule

@@ src/line_line_intersection.sv @@
// Top level of the two-line intersection pipeline.
// Takes one line pair per cycle while the output is not stalled and returns one
// result per pair, in order, through one multiplier stage, two stages for differences
// and magnitudes, one setup stage that detects quotients beyond the coordinate range,
// one restoring division stage per quotient bit, and the output register. Quotients
// are truncated toward zero and saturated; a zero determinant gives hit_count 0 and
// zero fields. A stall on the master side holds the whole pipeline.
module line_line_intersection (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // line1_a, line1_b, line1_c, line2_a, line2_b, line2_c (32 bits each)
    input  logic [lli_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // point_x [31:0], point_y [63:32]
    output logic [lli_pkg::OUT_W-1:0] m_axis_tdata,
    // hit_count [0], overflow [1]
    output logic [1:0]                m_axis_tuser
);

    localparam int CW = lli_pkg::COEF_WIDTH;
    localparam int FW = lli_pkg::FIELD_W;

    logic          en;
    lli_pkg::t_div stage [0:CW];

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    lli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_stage (stage[0])
    );

    for (genvar g = 0; g < CW; g++) begin : g_div
        lli_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (stage[g]),
            .o_stage (stage[g+1])
        );
    end

    lli_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (stage[CW]),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

    localparam logic [FW-1:0] SAT_MAX = FW'(signed'({1'b0, {(CW-1){1'b1}}}));
    localparam logic [FW-1:0] SAT_MIN = FW'(signed'({1'b1, {(CW-1){1'b0}}}));

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("parallel result carries nonzero fields");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[FW-1:0] == SAT_MAX || m_axis_tdata[FW-1:0] == SAT_MIN ||
            m_axis_tdata[2*FW-1:FW] == SAT_MAX || m_axis_tdata[2*FW-1:FW] == SAT_MIN)
        else $error("overflow without a saturated coordinate");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held off with an empty output register");

endmodule

@@ tb/line_line_intersection_tb.sv @@
// Self-checking testbench for the line pair intersection pipeline.
`timescale 1ns / 1ps

module line_line_intersection_tb;

    localparam int TIMEOUT_CYCLES = 20000;

    typedef struct packed {
        logic        hit;
        logic        ovf;
        logic [31:0] px;
        logic [31:0] py;
    } t_point;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [lli_pkg::IN_W-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [lli_pkg::OUT_W-1:0] m_axis_tdata;
    logic [1:0]                m_axis_tuser;

    t_point pending_points[$];
    int     n_errors = 0;
    int     n_beats_in = 0;
    int     n_beats_out = 0;
    int     n_parallel = 0;
    int     n_saturated = 0;
    int     idle_cycles = 0;
    int     sink_stall = 0;
    bit     sink_hold = 1'b0;
    bit     sink_busy_mode = 1'b1;

    line_line_intersection dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Truncated, saturated (num * 2^FRAC_BITS) / den on exact 128-bit values.
    function automatic logic [31:0] cramer_quotient(logic signed [127:0] num,
                                                    logic signed [127:0] den,
                                                    inout logic ovf);
        logic signed [127:0] q;
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (lli_pkg::COEF_WIDTH - 1)) - 1;
        lo = -(128'sd1 <<< (lli_pkg::COEF_WIDTH - 1));
        q = (num <<< lli_pkg::FRAC_BITS) / den;
        if (q > hi) begin
            q = hi;
            ovf = 1'b1;
        end else if (q < lo) begin
            q = lo;
            ovf = 1'b1;
        end
        return q[31:0];
    endfunction

    function automatic t_point intersect_lines(logic [lli_pkg::IN_W-1:0] d);
        logic signed [127:0] a1, b1, c1, a2, b2, c2, det;
        t_point p;
        a1 = $signed(d[31:0]);
        b1 = $signed(d[63:32]);
        c1 = $signed(d[95:64]);
        a2 = $signed(d[127:96]);
        b2 = $signed(d[159:128]);
        c2 = $signed(d[191:160]);
        det = a1 * b2 - b1 * a2;
        p = '0;
        if (det != 0) begin
            p.hit = 1'b1;
            p.px = cramer_quotient(b1 * c2 - c1 * b2, det, p.ovf);
            p.py = cramer_quotient(c1 * a2 - a1 * c2, det, p.ovf);
        end
        return p;
    endfunction

    task automatic send_lines(logic [lli_pkg::IN_W-1:0] d, bit allow_gap = 1'b1);
        int gap;
        if (allow_gap) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
            repeat (gap) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_points.push_back(intersect_lines(d));
        n_beats_in++;
    endtask

    task automatic release_source();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 8) << 16;
            2: return -($urandom_range(0, 8) << 16);
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            4: return $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 4000)) - 2000) <<< 8;
        endcase
    endfunction

    function automatic logic [lli_pkg::IN_W-1:0] random_pair();
        logic [31:0] a1, b1, a2, b2;
        int k;
        a1 = random_coef();
        b1 = random_coef();
        a2 = random_coef();
        b2 = random_coef();
        // make some pairs parallel by scaling the first normal
        if ($urandom_range(0, 7) == 0) begin
            k = $urandom_range(1, 4);
            a2 = a1 * k;
            b2 = b1 * k;
        end
        return {random_coef(), b2, a2, random_coef(), b1, a1};
    endfunction

    task automatic test_directed();
        logic [31:0] mx, mn, one, two;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        one = 32'h0001_0000;
        two = 32'h0002_0000;
        send_lines({-one, 32'h0, one, -one, 32'h0, one});
        send_lines({32'h0, one, one, 32'h0, one, one});
        send_lines({32'h0, two, two, 32'h0, one, one});
        send_lines({32'h0, one, one, mx, 32'h0, 32'h0});
        send_lines({mx, 32'h0, one, mx, one, 32'h1});
        send_lines({mn, 32'h1, 32'h0, mn, 32'h0, 32'h1});
        send_lines({mn, mn, mx, mn, mx, mn});
        send_lines({mx, mx, mx, mx, mx, mx});
        send_lines({mn, mn, mn, mn, mn, mn});
        send_lines({mn, 32'h0, 32'h1, mx, 32'h1, 32'h0});
        send_lines({mx, 32'h0, 32'h1, mn, 32'h1, 32'h0});
        send_lines({32'h0, mn, 32'h1, mn, 32'h0, 32'h1});
        send_lines({-one, one, -one, one, one, one});
        send_lines({32'h3, 32'hffff_ffff, 32'h7, 32'h5, 32'h2, 32'hffff_fff9});
        send_lines({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        send_lines({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_lines({$urandom(), 32'h0, 32'h0, $urandom(), 32'h0, 32'h0});
        release_source();
    endtask

    task automatic test_random_stream();
        repeat (1500) send_lines(random_pair());
        release_source();
    endtask

    // sink holds off for a long stretch while the source keeps pushing
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            repeat (120) send_lines(random_pair(), 1'b0);
        join
        release_source();
    endtask

    task automatic test_pause_then_burst();
        drain_results();
        sink_busy_mode = 1'b0;
        repeat (80) send_lines(random_pair(), 1'b0);
        release_source();
        sink_busy_mode = 1'b1;
    endtask

    // receiver: random stalls, long ones now and then, stretches with none
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_hold) begin
            m_axis_tready <= 1'b0;
        end else if (!sink_busy_mode) begin
            m_axis_tready <= 1'b1;
        end else if (sink_stall > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if ($urandom_range(0, 99) == 0) begin
            m_axis_tready <= 1'b0;
            sink_stall <= $urandom_range(10, 60);
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_point exp_point;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_beats_out++;
            if (pending_points.size() == 0) begin
                $display("%0t: result with nothing expected, got %h %b", $time,
                         m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                exp_point = pending_points.pop_front();
                if (!exp_point.hit) n_parallel++;
                if (exp_point.ovf) n_saturated++;
                if (m_axis_tuser[0] !== exp_point.hit) begin
                    $display("%0t: hit_count expected %0d got %0d", $time,
                             exp_point.hit, m_axis_tuser[0]);
                    n_errors++;
                end
                if (m_axis_tuser[1] !== exp_point.ovf) begin
                    $display("%0t: overflow expected %0d got %0d", $time,
                             exp_point.ovf, m_axis_tuser[1]);
                    n_errors++;
                end
                if (m_axis_tdata[31:0] !== exp_point.px) begin
                    $display("%0t: point_x expected %h got %h", $time,
                             exp_point.px, m_axis_tdata[31:0]);
                    n_errors++;
                end
                if (m_axis_tdata[63:32] !== exp_point.py) begin
                    $display("%0t: point_y expected %h got %h", $time,
                             exp_point.py, m_axis_tdata[63:32]);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || pending_points.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= TIMEOUT_CYCLES) begin
            $display("line_line_intersection: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_stream();
        test_pause_then_burst();
        drain_results();
        repeat (lli_pkg::COEF_WIDTH + 20) @(posedge i_clk);
        $display("Sent %0d line pairs, checked %0d results (%0d parallel, %0d saturated)",
                 n_beats_in, n_beats_out, n_parallel, n_saturated);
        if (n_errors == 0 && pending_points.size() == 0)
            $display("line_line_intersection: match");
        else
            $display("line_line_intersection: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
src/lli_pkg.sv
src/lli_front.sv
src/lli_div_step.sv
src/lli_back.sv
src/line_line_intersection.sv
tb/line_line_intersection_tb.sv
